// ----- rtl/flws_pkg.sv -----
// flws_pkg: types and codes shared by the flash log write sequencer
// request and response payloads, command, mode and flash operation codes
// no dependencies
package flws_pkg;

	typedef enum logic [2:0] {
		CMD_START     = 3'd0,
		CMD_ID_REPLY  = 3'd1,
		CMD_SCAN_BYTE = 3'd2,
		CMD_OP_DONE   = 3'd3,
		CMD_FLUSH     = 3'd4,
		CMD_ERASE_ALL = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		M_IDLE         = 3'd0,
		M_AWAIT_ID     = 3'd1,
		M_SCAN         = 3'd2,
		M_READY        = 3'd3,
		M_WRITING      = 3'd4,
		M_ERASE_SECTOR = 3'd5,
		M_FULL         = 3'd6,
		M_ERASE_DEVICE = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		OP_NONE         = 3'd0,
		OP_READ_ID      = 3'd1,
		OP_READ_PAGE    = 3'd2,
		OP_PROGRAM      = 3'd3,
		OP_ERASE_SECTOR = 3'd4,
		OP_ERASE_DEVICE = 3'd5
	} op_t;

	localparam logic [7:0] ERASED_BYTE = 8'hff;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] manufacturer;
		logic [7:0] memory_type;
		logic [4:0] capacity_log2;
		logic [7:0] scan_byte;
		logic       scan_last;
		logic [8:0] flush_length;
	} req_t;

	// per-request result, held in the output register
	typedef struct packed {
		op_t         issue_op;
		logic [30:0] op_address;
		logic [8:0]  op_length;
		logic        flush_done;
	} res_t;

	// status that follows directly from the sequencer state
	typedef struct packed {
		logic        initializing;
		logic        log_full;
		logic [31:0] free_bytes;
		logic [23:0] device_id;
	} status_t;

	typedef struct packed {
		logic [2:0]  issue_op;
		logic [30:0] op_address;
		logic [8:0]  op_length;
		logic        flush_done;
		logic        initializing;
		logic        log_full;
		logic [31:0] free_bytes;
		logic [23:0] device_id;
	} rsp_t;

endpackage

// ----- rtl/flws_req_if.sv -----
// flws_req_if: request channel of the flash log write sequencer
// valid/ready handshake carrying flws_pkg::req_t
interface flws_req_if;
	logic           valid;
	logic           ready;
	flws_pkg::req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/flws_rsp_if.sv -----
// flws_rsp_if: response channel of the flash log write sequencer
// valid/ready handshake carrying flws_pkg::rsp_t
interface flws_rsp_if;
	logic           valid;
	logic           ready;
	flws_pkg::rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/flws_ctrl.sv -----
// flws_ctrl: sequencer state and the single-pass next-state logic
// produces the result of the current request and the status from the state
// depends on flws_pkg
module flws_ctrl #(
	parameter int PAGE_BYTES   = 256,
	parameter int SECTOR_BYTES = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  flws_pkg::req_t    req,
	output flws_pkg::res_t    res,
	output flws_pkg::status_t status
);

	localparam int OFF_W = $clog2(SECTOR_BYTES);
	localparam logic [31:0] PAGE_W = 32'(PAGE_BYTES);
	localparam logic [31:0] SECTOR_W = 32'(SECTOR_BYTES);
	localparam logic [8:0] PAGE_LEN = PAGE_W[8:0];
	localparam logic [OFF_W:0] PAGE_MOD = (OFF_W + 1)'(PAGE_BYTES % SECTOR_BYTES);
	localparam logic [OFF_W:0] SECTOR_LIM = (OFF_W + 1)'(SECTOR_BYTES);

	flws_pkg::mode_t  mode_q, mode_n;
	logic [31:0]      addr_q, addr_n;
	logic [OFF_W-1:0] off_q, off_n;
	logic [31:0]      size_q, size_n;
	logic [23:0]      id_q, id_n;
	logic             erased_q, erased_n;
	logic             pend_q, pend_n;
	logic [8:0]       plen_q, plen_n;

	logic [31:0]      addr_sec, addr_pg;
	logic [OFF_W:0]   off_sum;
	logic [OFF_W-1:0] off_pg;
	logic             erased_now;
	logic             go_ready;
	logic             prog;
	logic [8:0]       prog_len;

	assign addr_sec = addr_q + SECTOR_W;
	assign addr_pg  = addr_q + PAGE_W;
	// offset within the sector, kept beside the address
	assign off_sum  = {1'b0, off_q} + PAGE_MOD;
	assign off_pg   = (off_sum >= SECTOR_LIM) ? OFF_W'(off_sum - SECTOR_LIM) : off_sum[OFF_W-1:0];
	assign erased_now = erased_q & (req.scan_byte == flws_pkg::ERASED_BYTE);

	always_comb begin
		mode_n   = mode_q;
		addr_n   = addr_q;
		off_n    = off_q;
		size_n   = size_q;
		id_n     = id_q;
		erased_n = erased_q;
		pend_n   = pend_q;
		plen_n   = plen_q;
		go_ready = 1'b0;
		prog     = 1'b0;
		prog_len = req.flush_length;
		res.issue_op   = flws_pkg::OP_NONE;
		res.op_address = '0;
		res.op_length  = '0;
		res.flush_done = 1'b0;

		case (req.cmd)
			flws_pkg::CMD_START: begin
				if (mode_q == flws_pkg::M_IDLE) begin
					res.issue_op = flws_pkg::OP_READ_ID;
					mode_n = flws_pkg::M_AWAIT_ID;
				end
			end
			flws_pkg::CMD_ID_REPLY: begin
				if (mode_q == flws_pkg::M_AWAIT_ID) begin
					id_n     = {req.manufacturer, req.memory_type, 3'b000, req.capacity_log2};
					size_n   = 32'(1) << req.capacity_log2;
					erased_n = 1'b1;
					res.issue_op   = flws_pkg::OP_READ_PAGE;
					res.op_address = addr_q[30:0];
					res.op_length  = PAGE_LEN;
					mode_n = flws_pkg::M_SCAN;
				end
			end
			flws_pkg::CMD_SCAN_BYTE: begin
				if (mode_q == flws_pkg::M_SCAN) begin
					erased_n = erased_now;
					if (req.scan_last) begin
						erased_n = 1'b1;
						if (erased_now) begin
							go_ready = 1'b1;
						end else begin
							// page in use, step to the next sector
							addr_n = addr_sec;
							if (addr_sec >= size_q) begin
								mode_n = flws_pkg::M_FULL;
							end else begin
								res.issue_op   = flws_pkg::OP_READ_PAGE;
								res.op_address = addr_sec[30:0];
								res.op_length  = PAGE_LEN;
							end
						end
					end
				end
			end
			flws_pkg::CMD_OP_DONE: begin
				case (mode_q)
					flws_pkg::M_WRITING: begin
						res.flush_done = 1'b1;
						addr_n = addr_pg;
						off_n  = off_pg;
						if (addr_pg >= size_q) begin
							mode_n = flws_pkg::M_FULL;
						end else if (off_pg == '0) begin
							res.issue_op   = flws_pkg::OP_ERASE_SECTOR;
							res.op_address = addr_pg[30:0];
							mode_n = flws_pkg::M_ERASE_SECTOR;
						end else begin
							go_ready = 1'b1;
						end
					end
					flws_pkg::M_ERASE_SECTOR: begin
						go_ready = 1'b1;
					end
					flws_pkg::M_ERASE_DEVICE: begin
						addr_n = '0;
						off_n  = '0;
						res.issue_op = flws_pkg::OP_READ_ID;
						mode_n = flws_pkg::M_AWAIT_ID;
					end
					default: begin
					end
				endcase
			end
			flws_pkg::CMD_FLUSH: begin
				if (mode_q == flws_pkg::M_READY) begin
					prog = 1'b1;
				end else begin
					pend_n = 1'b1;
					plen_n = req.flush_length;
				end
			end
			flws_pkg::CMD_ERASE_ALL: begin
				res.issue_op = flws_pkg::OP_ERASE_DEVICE;
				mode_n = flws_pkg::M_ERASE_DEVICE;
			end
			default: begin
			end
		endcase

		// a deferred flush goes out as soon as the block is ready
		if (go_ready) begin
			if (pend_q) begin
				pend_n   = 1'b0;
				prog     = 1'b1;
				prog_len = plen_q;
			end else begin
				mode_n = flws_pkg::M_READY;
			end
		end

		if (prog) begin
			res.issue_op   = flws_pkg::OP_PROGRAM;
			res.op_address = addr_n[30:0];
			res.op_length  = ({23'b0, prog_len} > PAGE_W) ? PAGE_LEN : prog_len;
			mode_n = flws_pkg::M_WRITING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= flws_pkg::M_IDLE;
			addr_q   <= '0;
			off_q    <= '0;
			size_q   <= '0;
			id_q     <= '0;
			erased_q <= 1'b1;
			pend_q   <= 1'b0;
			plen_q   <= '0;
		end else if (accept) begin
			mode_q   <= mode_n;
			addr_q   <= addr_n;
			off_q    <= off_n;
			size_q   <= size_n;
			id_q     <= id_n;
			erased_q <= erased_n;
			pend_q   <= pend_n;
			plen_q   <= plen_n;
		end
	end

	assign status.initializing = (mode_q == flws_pkg::M_IDLE) || (mode_q == flws_pkg::M_AWAIT_ID)
		|| (mode_q == flws_pkg::M_SCAN);
	assign status.log_full   = (mode_q == flws_pkg::M_FULL);
	assign status.free_bytes = (size_q > addr_q) ? (size_q - addr_q) : '0;
	assign status.device_id  = id_q;

	a_ready_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == flws_pkg::M_READY) |-> !pend_q)
		else $error("flush left pending in ready mode");

	a_full_address: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == flws_pkg::M_FULL) |-> (addr_q >= size_q))
		else $error("full mode with write address below device size");

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == flws_pkg::M_FULL) |=>
		(mode_q == flws_pkg::M_FULL) || (mode_q == flws_pkg::M_ERASE_DEVICE))
		else $error("left full mode other than by device erase");

	a_ready_flush_programs: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.cmd == flws_pkg::CMD_FLUSH) && (mode_q == flws_pkg::M_READY))
		|=> (mode_q == flws_pkg::M_WRITING))
		else $error("flush in ready mode did not start a program");

endmodule

// ----- rtl/flws_out_reg.sv -----
// flws_out_reg: result register between the sequencer logic and the response channel
// loads on every accepted request, holds while the sink stalls
// depends on flws_pkg
module flws_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  flws_pkg::res_t res_d,
	input  logic           out_ready,
	output logic           out_valid,
	output flws_pkg::res_t res_q,
	output logic           in_ready
);

	logic valid_q;

	// slot is free when empty or being drained this cycle
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

endmodule

// ----- rtl/flash_log_write_sequencer.sv -----
// flash_log_write_sequencer: top level of the append-only flash log sequencer
// depends on flws_pkg, flws_req_if, flws_rsp_if, flws_ctrl, flws_out_reg
//
//   channel  dir  payload   meaning
//   req      in   req_t     event: start, id reply, scan byte, op done, flush, erase all
//   rsp      out  rsp_t     issued flash operation and status, one per request
//
// one request per cycle while rsp does not stall, response valid in the cycle after accept
// the state update and result come from one pass of logic in flws_ctrl
// a response waiting in the output register blocks new requests only while rsp stalls
// reset clears the mode to idle, address, size and id to zero
module flash_log_write_sequencer #(
	parameter int PAGE_BYTES   = 256,
	parameter int SECTOR_BYTES = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	flws_req_if.sink   req,
	flws_rsp_if.source rsp
);

	flws_pkg::res_t    res_d, res_q;
	flws_pkg::status_t status;
	logic              accept;
	logic              in_ready;

	assign req.ready = in_ready;
	assign accept    = req.valid && in_ready;

	flws_ctrl #(
		.PAGE_BYTES   (PAGE_BYTES),
		.SECTOR_BYTES (SECTOR_BYTES)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req.payload),
		.res    (res_d),
		.status (status)
	);

	flws_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.res_d     (res_d),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.res_q     (res_q),
		.in_ready  (in_ready)
	);

	// status tracks the state left by the request held in the output register
	assign rsp.payload.issue_op     = res_q.issue_op;
	assign rsp.payload.op_address   = res_q.op_address;
	assign rsp.payload.op_length    = res_q.op_length;
	assign rsp.payload.flush_done   = res_q.flush_done;
	assign rsp.payload.initializing = status.initializing;
	assign rsp.payload.log_full     = status.log_full;
	assign rsp.payload.free_bytes   = status.free_bytes;
	assign rsp.payload.device_id    = status.device_id;

endmodule

// ----- tb/testbench.sv -----
// testbench: self-checking bench for flash_log_write_sequencer
// predicts each response from its own model of the sequencer state and checks it field by field
// depends on flws_pkg, flws_req_if, flws_rsp_if and the sequencer rtl
module testbench;
	import flws_pkg::*;

	localparam int PAGE   = 256;
	localparam int SECTOR = 4096;
	localparam int RANDOM_EVENTS = 1750;
	localparam int HOLD_AT = 800;
	localparam int HOLD_CYCLES = 250;
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	class log_scoreboard;
		mode_t       mode;
		logic [31:0] wr_addr;
		logic [31:0] dev_size;
		logic [23:0] id_word;
		bit          all_erased;
		bit          flush_pend;
		logic [8:0]  pend_len;
		op_t         op;
		logic [31:0] op_addr;
		logic [8:0]  op_len;
		rsp_t        expected_q[$];
		int          errors;
		int          accepted;

		function new();
			mode = M_IDLE;
			wr_addr = '0;
			dev_size = '0;
			id_word = '0;
			all_erased = 1'b1;
			flush_pend = 1'b0;
			pend_len = '0;
			errors = 0;
			accepted = 0;
		endfunction

		function void issue(op_t o, logic [31:0] a, logic [8:0] l);
			op = o;
			op_addr = a;
			op_len = l;
		endfunction

		function void program_page(logic [8:0] l);
			issue(OP_PROGRAM, wr_addr, (l > PAGE) ? 9'(PAGE) : l);
			mode = M_WRITING;
		endfunction

		function void enter_ready();
			mode = M_READY;
			if (flush_pend) begin
				flush_pend = 1'b0;
				program_page(pend_len);
			end
		endfunction

		function void begin_scan();
			all_erased = 1'b1;
			issue(OP_READ_PAGE, wr_addr, 9'(PAGE));
			mode = M_SCAN;
		endfunction

		// works out the response of one accepted request and queues it
		function void note_request(req_t r);
			rsp_t e;
			bit   done;
			done = 1'b0;
			accepted++;
			issue(OP_NONE, '0, '0);
			case (r.cmd)
				CMD_START: begin
					if (mode == M_IDLE) begin
						issue(OP_READ_ID, '0, '0);
						mode = M_AWAIT_ID;
					end
				end
				CMD_ID_REPLY: begin
					if (mode == M_AWAIT_ID) begin
						id_word = {r.manufacturer, r.memory_type, 3'b000, r.capacity_log2};
						dev_size = 32'd1 << r.capacity_log2;
						begin_scan();
					end
				end
				CMD_SCAN_BYTE: begin
					if (mode == M_SCAN) begin
						if (r.scan_byte != ERASED_BYTE)
							all_erased = 1'b0;
						if (r.scan_last) begin
							if (all_erased) begin
								enter_ready();
							end else begin
								wr_addr += SECTOR;
								if (wr_addr >= dev_size) begin
									all_erased = 1'b1;
									mode = M_FULL;
								end else begin
									begin_scan();
								end
							end
						end
					end
				end
				CMD_OP_DONE: begin
					if (mode == M_WRITING) begin
						done = 1'b1;
						wr_addr += PAGE;
						if (wr_addr >= dev_size) begin
							mode = M_FULL;
						end else if (wr_addr % SECTOR == 0) begin
							issue(OP_ERASE_SECTOR, wr_addr, '0);
							mode = M_ERASE_SECTOR;
						end else begin
							enter_ready();
						end
					end else if (mode == M_ERASE_SECTOR) begin
						enter_ready();
					end else if (mode == M_ERASE_DEVICE) begin
						wr_addr = '0;
						issue(OP_READ_ID, '0, '0);
						mode = M_AWAIT_ID;
					end
				end
				CMD_FLUSH: begin
					if (mode == M_READY) begin
						program_page(r.flush_length);
					end else begin
						flush_pend = 1'b1;
						pend_len = r.flush_length;
					end
				end
				CMD_ERASE_ALL: begin
					issue(OP_ERASE_DEVICE, '0, '0);
					mode = M_ERASE_DEVICE;
				end
				default: ;
			endcase
			e.issue_op = op;
			e.op_address = op_addr[30:0];
			e.op_length = op_len;
			e.flush_done = done;
			e.initializing = (mode == M_IDLE || mode == M_AWAIT_ID || mode == M_SCAN);
			e.log_full = (mode == M_FULL);
			e.free_bytes = (dev_size > wr_addr) ? dev_size - wr_addr : '0;
			e.device_id = id_word;
			expected_q.push_back(e);
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (expected_q.size() == 0) begin
				$error("response with no request outstanding: 0x%0h", got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare("issue_op", 32'(want.issue_op), 32'(got.issue_op));
			compare("op_address", 32'(want.op_address), 32'(got.op_address));
			compare("op_length", 32'(want.op_length), 32'(got.op_length));
			compare("flush_done", 32'(want.flush_done), 32'(got.flush_done));
			compare("initializing", 32'(want.initializing), 32'(got.initializing));
			compare("log_full", 32'(want.log_full), 32'(got.log_full));
			compare("free_bytes", want.free_bytes, got.free_bytes);
			compare("device_id", 32'(want.device_id), 32'(got.device_id));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	flws_req_if req_ch();
	flws_rsp_if rsp_ch();
	log_scoreboard sb;
	int quiet_left;
	int hold_left;
	int run_left;
	bit hold_done;
	bit blank_page;

	flash_log_write_sequencer #(
		.PAGE_BYTES  (PAGE),
		.SECTOR_BYTES(SECTOR)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#6000000;
		$display("Simulation FAILED");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic req_t ev(logic [2:0] c);
		req_t r;
		r.cmd = c;
		r.manufacturer = 8'($urandom_range(0, 255));
		r.memory_type = 8'($urandom_range(0, 255));
		r.capacity_log2 = 5'($urandom_range(0, 31));
		r.scan_byte = 8'($urandom_range(0, 255));
		r.scan_last = 1'($urandom_range(0, 1));
		r.flush_length = 9'($urandom_range(0, 511));
		return r;
	endfunction

	task automatic send_request(input req_t r);
		int gap;
		if (quiet_left > 0) begin
			gap = 0;
			quiet_left--;
		end else begin
			gap = idle_len();
			if ($urandom_range(0, 99) == 0)
				quiet_left = 50;
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= r;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(r);
	endtask

	// response side: random stalls, one long hold once HOLD_AT requests have been accepted
	initial begin
		rsp_ch.ready <= 1'b0;
		hold_left = 0;
		run_left = 0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response(rsp_ch.payload);
			if (!hold_done && sb.accepted >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (run_left > 0) begin
				run_left--;
				rsp_ch.ready <= 1'b1;
			end else if ($urandom_range(0, 99) < 2) begin
				run_left = 60;
				rsp_ch.ready <= 1'b1;
			end else begin
				hold_left = idle_len();
				if (hold_left > 0)
					hold_left--;
				rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 3) != 0);
			end
		end
	end

	initial begin
		req_t r;
		int   pick;
		int   sel;
		sb = new();
		quiet_left = 0;
		blank_page = 1'b1;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.payload <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// flush before start is held and later clamped to one page
		r = ev(CMD_FLUSH);
		r.flush_length = 9'd511;
		send_request(r);
		send_request(ev(CMD_SPARE_6));
		send_request(ev(CMD_SPARE_7));
		send_request(ev(CMD_OP_DONE));
		send_request(ev(CMD_SCAN_BYTE));
		send_request(ev(CMD_START));
		send_request(ev(CMD_START));
		r = ev(CMD_ID_REPLY);
		r.manufacturer = 8'hff;
		r.memory_type = 8'h00;
		r.capacity_log2 = 5'd13;
		send_request(r);
		r = ev(CMD_SCAN_BYTE);
		r.scan_byte = 8'h00;
		r.scan_last = 1'b0;
		send_request(r);
		r = ev(CMD_SCAN_BYTE);
		r.scan_byte = ERASED_BYTE;
		r.scan_last = 1'b1;
		send_request(r);
		send_request(r);
		// flush while writing stays pending until the program completes
		r = ev(CMD_FLUSH);
		r.flush_length = 9'd5;
		send_request(r);
		send_request(ev(CMD_OP_DONE));
		send_request(ev(CMD_OP_DONE));
		r = ev(CMD_FLUSH);
		r.flush_length = 9'd0;
		send_request(r);
		send_request(ev(CMD_OP_DONE));
		send_request(ev(CMD_ERASE_ALL));
		send_request(ev(CMD_OP_DONE));
		// one-byte device: scan runs past the size and the log is full
		r = ev(CMD_ID_REPLY);
		r.manufacturer = 8'h00;
		r.memory_type = 8'hff;
		r.capacity_log2 = 5'd0;
		send_request(r);
		r = ev(CMD_SCAN_BYTE);
		r.scan_byte = 8'h12;
		r.scan_last = 1'b1;
		send_request(r);
		r = ev(CMD_FLUSH);
		r.flush_length = 9'd256;
		send_request(r);
		send_request(ev(CMD_ERASE_ALL));
		send_request(ev(CMD_OP_DONE));
		r = ev(CMD_ID_REPLY);
		r.manufacturer = 8'ha5;
		r.memory_type = 8'h5a;
		r.capacity_log2 = 5'd31;
		send_request(r);
		r = ev(CMD_SCAN_BYTE);
		r.scan_byte = ERASED_BYTE;
		r.scan_last = 1'b1;
		send_request(r);
		send_request(ev(CMD_OP_DONE));

		// mostly legal event flows for the current mode, some noise
		for (int n = 0; n < RANDOM_EVENTS; n++) begin
			r = ev(3'($urandom_range(0, 7)));
			pick = $urandom_range(0, 99);
			sel = $urandom_range(0, 99);
			if (pick >= 8) begin
				case (sb.mode)
					M_IDLE: r.cmd = CMD_START;
					M_AWAIT_ID: begin
						r.cmd = CMD_ID_REPLY;
						if (sel < 60)
							r.capacity_log2 = 5'($urandom_range(12, 14));
						else if (sel < 80)
							r.capacity_log2 = 5'($urandom_range(0, 11));
						else
							r.capacity_log2 = 5'($urandom_range(15, 31));
					end
					M_SCAN: begin
						r.cmd = CMD_SCAN_BYTE;
						if (blank_page)
							r.scan_byte = ERASED_BYTE;
						r.scan_last = (sel < 17);
						if (r.scan_last)
							blank_page = ($urandom_range(0, 9) < 4);
					end
					M_READY: begin
						if (sel < 97) begin
							r.cmd = CMD_FLUSH;
							if (pick < 80)
								r.flush_length = 9'($urandom_range(1, 256));
						end else begin
							r.cmd = CMD_ERASE_ALL;
						end
					end
					M_FULL: r.cmd = (sel < 75) ? CMD_ERASE_ALL : CMD_FLUSH;
					default: begin
						if (sel < 85)
							r.cmd = CMD_OP_DONE;
						else if (sel < 95)
							r.cmd = CMD_FLUSH;
						else
							r.cmd = CMD_ERASE_ALL;
					end
				endcase
			end
			send_request(r);
		end
		req_ch.valid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/flws_pkg.sv
rtl/flws_req_if.sv
rtl/flws_rsp_if.sv
rtl/flws_ctrl.sv
rtl/flws_out_reg.sv
rtl/flash_log_write_sequencer.sv
tb/testbench.sv
